// File: hdl/h2r_pkg.sv
// shared types, constants and helpers for the hsv to rgb565 converter
// no dependencies; imported by every module of the block
package h2r_pkg;

    // hue wrap: hue + 6 turns is always positive, then reduced mod one turn
    localparam logic [16:0] HUE_BIAS    = 17'd34560;
    localparam logic [12:0] HUE_TURN    = 13'd5760;
    // one turn is 45 blocks of 128 hue steps
    localparam logic [9:0]  WRAP_BLOCKS = 10'd45;
    localparam logic [6:0]  WRAP_RECIP  = 7'd91;    // floor(4096 / 45)
    localparam int          WRAP_SHIFT  = 12;

    localparam logic [9:0]  SECT_SPAN   = 10'd960;  // 60 degrees in hue steps
    localparam logic [7:0]  LVL_MAX     = 8'd255;

    // level = num / (255 * 960) by reciprocal and one correction
    localparam logic [17:0] DIV_DEN     = 18'd244800;
    localparam logic [8:0]  DIV_RECIP   = 9'd274;   // floor(2^26 / 244800)
    localparam int          DIV_SHIFT   = 26;

    // sector codes
    localparam logic [2:0]  SECT_RY = 3'd0;
    localparam logic [2:0]  SECT_YG = 3'd1;
    localparam logic [2:0]  SECT_GC = 3'd2;
    localparam logic [2:0]  SECT_CB = 3'd3;
    localparam logic [2:0]  SECT_BM = 3'd4;
    localparam logic [2:0]  SECT_MR = 3'd5;

    typedef struct packed {
        logic signed [15:0] hue;
        logic [7:0]         sat;
        logic [7:0]         val;
    } t_hsv;

    typedef struct packed {
        logic [2:0] sector;
        logic [9:0] weight;
        logic [7:0] sat;
        logic [7:0] val;
    } t_sect;

    typedef struct packed {
        logic [25:0] num_r;
        logic [25:0] num_g;
        logic [25:0] num_b;
    } t_num;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // start of a sector in hue steps
    function automatic logic [12:0] sect_base(input logic [2:0] s);
        return 13'(s) * 13'(SECT_SPAN);
    endfunction

endpackage

// File: hdl/hsv_to_rgb565.sv
// top level of the hsv to rgb565 converter: stream ports and output packing
// depends on h2r_pkg, h2r_hue, h2r_mix and h2r_div

// Converts one pixel per clock from hsv (signed hue in 1/16 degree, saturation
// and value scaled so 255 is full) to 8-bit red, green and blue plus the packed
// rgb565 word. The pipeline has seven register stages: three for the hue wrap,
// sector pick and secondary weight, two for the channel numerators (the
// v*s and v*(255-s) products, then the 16x10 share products), and two for the
// divide by 255*960 (reciprocal multiply, then a one-step correction). Throughput
// is one beat per clock while m_axis tready is held high, with no dependence
// between pixels. Each stage has its own valid bit and advances whenever the
// stage after it is empty or moving, so a stall on the output only holds the
// stages that are full and bubbles are squeezed out; s_axis tready follows that
// chain combinationally from m_axis tready. Results are exact: channel =
// floor((share + m) * 255), clamped to 255, with 60-degree boundaries belonging
// to the higher sector.
module hsv_to_rgb565 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // red_level[7:0], green_level[15:8],
                                          // blue_level[23:16], pixel_word[39:24]
);
    import h2r_pkg::*;

    t_hsv  w_in;
    t_sect w_sect;
    t_num  w_num;
    t_rgb  w_rgb;
    logic  w_sect_vld;
    logic  w_sect_rdy;
    logic  w_num_vld;
    logic  w_num_rdy;
    logic [15:0] w_pixel;

    // unpack the input beat
    assign w_in.hue = i_s_axis_tdata[15:0];
    assign w_in.sat = i_s_axis_tdata[23:16];
    assign w_in.val = i_s_axis_tdata[31:24];

    // hue wrap, sector and weight
    h2r_hue u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_beat  (w_in),
        .o_valid (w_sect_vld),
        .i_ready (w_sect_rdy),
        .o_beat  (w_sect)
    );

    // per-channel numerators
    h2r_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sect_vld),
        .o_ready (w_sect_rdy),
        .i_beat  (w_sect),
        .o_valid (w_num_vld),
        .i_ready (w_num_rdy),
        .o_beat  (w_num)
    );

    // divide to 8-bit levels; its last stage is the output register
    h2r_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_num_vld),
        .o_ready (w_num_rdy),
        .i_beat  (w_num),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_beat  (w_rgb)
    );

    // rgb565 from the top bits of each channel
    assign w_pixel = {w_rgb.red[7:3], w_rgb.green[7:2], w_rgb.blue[7:3]};

    assign o_m_axis_tdata = {w_pixel, w_rgb.blue, w_rgb.green, w_rgb.red};

endmodule

// File: hdl/h2r_hue.sv
// hue wrap, sector pick and secondary weight, three pipeline stages
// depends on h2r_pkg
module h2r_hue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  h2r_pkg::t_hsv   i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output h2r_pkg::t_sect  o_beat
);
    import h2r_pkg::*;

    // stage a: coarse reduction of the biased hue
    logic        r_va;
    logic [6:0]  r_rem_a;
    logic [6:0]  r_low_a;
    logic [7:0]  r_sat_a;
    logic [7:0]  r_val_a;
    // stage b: wrapped hue and sector
    logic        r_vb;
    logic [12:0] r_hw_b;
    logic [2:0]  r_sect_b;
    logic [7:0]  r_sat_b;
    logic [7:0]  r_val_b;
    // stage c: weight of the secondary channel
    logic        r_vc;
    logic [2:0]  r_sect_c;
    logic [9:0]  r_wt_c;
    logic [7:0]  r_sat_c;
    logic [7:0]  r_val_c;

    logic        w_ld_a;
    logic        w_ld_b;
    logic        w_ld_c;

    logic [16:0] w_biased;
    logic [9:0]  w_blk;
    logic [15:0] w_prod;
    logic [3:0]  w_q;
    logic [9:0]  w_rem;
    logic [6:0]  n_rem_a;
    logic [6:0]  w_rc;
    logic [12:0] n_hw_b;
    logic [2:0]  n_sect_b;
    logic [12:0] w_wt;
    logic [9:0]  n_wt_c;

    assign w_ld_c  = !r_vc || i_ready;
    assign w_ld_b  = !r_vb || w_ld_c;
    assign w_ld_a  = !r_va || w_ld_b;
    assign o_ready = w_ld_a;

    // biased hue lies in 1792..67327, so 17 bits hold it exactly
    assign w_biased = {i_beat.hue[15], i_beat.hue} + HUE_BIAS;
    assign w_blk    = w_biased[16:7];
    assign w_prod   = 16'(w_blk) * 16'(WRAP_RECIP);
    assign w_q      = w_prod[WRAP_SHIFT+3:WRAP_SHIFT];
    // quotient estimate is exact or one low, remainder below 90
    assign w_rem    = w_blk - 10'(w_q) * WRAP_BLOCKS;
    assign n_rem_a  = w_rem[6:0];

    assign w_rc   = (r_rem_a >= 7'(WRAP_BLOCKS)) ? r_rem_a - 7'(WRAP_BLOCKS) : r_rem_a;
    assign n_hw_b = {w_rc[5:0], r_low_a};

    always_comb begin
        if (n_hw_b >= sect_base(SECT_MR)) begin
            n_sect_b = SECT_MR;
        end else if (n_hw_b >= sect_base(SECT_BM)) begin
            n_sect_b = SECT_BM;
        end else if (n_hw_b >= sect_base(SECT_CB)) begin
            n_sect_b = SECT_CB;
        end else if (n_hw_b >= sect_base(SECT_GC)) begin
            n_sect_b = SECT_GC;
        end else if (n_hw_b >= sect_base(SECT_YG)) begin
            n_sect_b = SECT_YG;
        end else begin
            n_sect_b = SECT_RY;
        end
    end

    // rising edge in even sectors, falling edge in odd ones
    assign w_wt   = r_sect_b[0] ? sect_base(r_sect_b + 3'd1) - r_hw_b
                                : r_hw_b - sect_base(r_sect_b);
    assign n_wt_c = w_wt[9:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_ld_a) begin
                r_va <= i_valid;
            end
            if (w_ld_b) begin
                r_vb <= r_va;
            end
            if (w_ld_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a && i_valid) begin
            r_rem_a <= n_rem_a;
            r_low_a <= w_biased[6:0];
            r_sat_a <= i_beat.sat;
            r_val_a <= i_beat.val;
        end
        if (w_ld_b && r_va) begin
            r_hw_b   <= n_hw_b;
            r_sect_b <= n_sect_b;
            r_sat_b  <= r_sat_a;
            r_val_b  <= r_val_a;
        end
        if (w_ld_c && r_vb) begin
            r_sect_c <= r_sect_b;
            r_wt_c   <= n_wt_c;
            r_sat_c  <= r_sat_b;
            r_val_c  <= r_val_b;
        end
    end

    assign o_valid       = r_vc;
    assign o_beat.sector = r_sect_c;
    assign o_beat.weight = r_wt_c;
    assign o_beat.sat    = r_sat_c;
    assign o_beat.val    = r_val_c;

`ifndef ASSERT_OFF
    a_hw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (r_hw_b < HUE_TURN))
        else $error("wrapped hue out of range");

    a_sect_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (r_hw_b >= sect_base(r_sect_b)) && (r_hw_b < sect_base(r_sect_b + 3'd1)))
        else $error("sector does not contain hue");

    a_wt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc |-> (r_wt_c <= SECT_SPAN))
        else $error("secondary weight above one sector");

    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && !w_ld_c) |=> (r_vb && $stable(r_hw_b) && $stable(r_sect_b)))
        else $error("stage b lost its beat during a stall");
`endif

endmodule

// File: hdl/h2r_mix.sv
// channel shares by sector and the per-channel numerators, two stages
// depends on h2r_pkg
module h2r_mix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  h2r_pkg::t_sect  i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output h2r_pkg::t_num   o_beat
);
    import h2r_pkg::*;

    logic        r_vd;
    logic [9:0]  r_kr_d;
    logic [9:0]  r_kg_d;
    logic [9:0]  r_kb_d;
    logic [15:0] r_vs_d;
    logic [15:0] r_vn_d;
    logic        r_ve;
    t_num        r_num_e;

    logic        w_ld_d;
    logic        w_ld_e;
    logic [9:0]  n_kr;
    logic [9:0]  n_kg;
    logic [9:0]  n_kb;
    logic [15:0] n_vs;
    logic [15:0] n_vn;
    t_num        n_num;
    logic [25:0] w_off;

    assign w_ld_e  = !r_ve || i_ready;
    assign w_ld_d  = !r_vd || w_ld_e;
    assign o_ready = w_ld_d;

    always_comb begin
        n_kr = '0;
        n_kg = '0;
        n_kb = '0;
        case (i_beat.sector)
            SECT_RY: begin
                n_kr = SECT_SPAN;
                n_kg = i_beat.weight;
            end
            SECT_YG: begin
                n_kr = i_beat.weight;
                n_kg = SECT_SPAN;
            end
            SECT_GC: begin
                n_kg = SECT_SPAN;
                n_kb = i_beat.weight;
            end
            SECT_CB: begin
                n_kg = i_beat.weight;
                n_kb = SECT_SPAN;
            end
            SECT_BM: begin
                n_kr = i_beat.weight;
                n_kb = SECT_SPAN;
            end
            default: begin
                n_kr = SECT_SPAN;
                n_kb = i_beat.weight;
            end
        endcase
    end

    // v*s and v*(255-s)
    assign n_vs = 16'(i_beat.val) * 16'(i_beat.sat);
    assign n_vn = 16'(i_beat.val) * 16'(LVL_MAX - i_beat.sat);

    // offset term shared by all channels
    assign w_off       = 26'(r_vn_d) * 26'(SECT_SPAN);
    assign n_num.num_r = 26'(r_vs_d) * 26'(r_kr_d) + w_off;
    assign n_num.num_g = 26'(r_vs_d) * 26'(r_kg_d) + w_off;
    assign n_num.num_b = 26'(r_vs_d) * 26'(r_kb_d) + w_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (w_ld_d) begin
                r_vd <= i_valid;
            end
            if (w_ld_e) begin
                r_ve <= r_vd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_d && i_valid) begin
            r_kr_d <= n_kr;
            r_kg_d <= n_kg;
            r_kb_d <= n_kb;
            r_vs_d <= n_vs;
            r_vn_d <= n_vn;
        end
        if (w_ld_e && r_vd) begin
            r_num_e <= n_num;
        end
    end

    assign o_valid = r_ve;
    assign o_beat  = r_num_e;

endmodule

// File: hdl/h2r_div.sv
// divide each numerator by 255*960 with a reciprocal and a correction, two stages
// depends on h2r_pkg
module h2r_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  h2r_pkg::t_num   i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output h2r_pkg::t_rgb   o_beat
);
    import h2r_pkg::*;

    // quotient estimate, exact or one low for numerators below 2^26
    function automatic logic [7:0] quot_est(input logic [25:0] n);
        logic [34:0] p;
        p = 35'(n) * 35'(DIV_RECIP);
        return p[DIV_SHIFT+7:DIV_SHIFT];
    endfunction

    // fix the estimate up by one and clamp
    function automatic logic [7:0] quot_fix(input logic [25:0] n, input logic [7:0] q);
        logic [25:0] rem;
        logic [8:0]  lvl;
        rem = n - 26'(q) * 26'(DIV_DEN);
        lvl = (rem >= 26'(DIV_DEN)) ? 9'(q) + 9'd1 : 9'(q);
        return (lvl > 9'(LVL_MAX)) ? LVL_MAX : lvl[7:0];
    endfunction

    logic        r_vf;
    t_num        r_num_f;
    logic [7:0]  r_qr_f;
    logic [7:0]  r_qg_f;
    logic [7:0]  r_qb_f;
    logic        r_vg;
    t_rgb        r_rgb_g;

    logic        w_ld_f;
    logic        w_ld_g;
    t_rgb        n_rgb;

    assign w_ld_g  = !r_vg || i_ready;
    assign w_ld_f  = !r_vf || w_ld_g;
    assign o_ready = w_ld_f;

    assign n_rgb.red   = quot_fix(r_num_f.num_r, r_qr_f);
    assign n_rgb.green = quot_fix(r_num_f.num_g, r_qg_f);
    assign n_rgb.blue  = quot_fix(r_num_f.num_b, r_qb_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vg <= 1'b0;
        end else begin
            if (w_ld_f) begin
                r_vf <= i_valid;
            end
            if (w_ld_g) begin
                r_vg <= r_vf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_f && i_valid) begin
            r_num_f <= i_beat;
            r_qr_f  <= quot_est(i_beat.num_r);
            r_qg_f  <= quot_est(i_beat.num_g);
            r_qb_f  <= quot_est(i_beat.num_b);
        end
        if (w_ld_g && r_vf) begin
            r_rgb_g <= n_rgb;
        end
    end

    assign o_valid = r_vg;
    assign o_beat  = r_rgb_g;

endmodule
